// File: rtl/core/prq_pkg.sv
package prq_pkg;

    // Sizing
    localparam int LEVELS = 32;
    localparam int TASKS  = 128;

    localparam int TASK_W = $clog2(TASKS);
    localparam int LINK_W = $clog2(TASKS + 1);
    localparam int LVL_W  = $clog2(LEVELS);

    // Fixed stream field widths
    localparam int FUNC_W      = 3;
    localparam int TASK_REQ_W  = 7;
    localparam int LEVEL_REQ_W = 5;
    localparam int CHOSEN_W    = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    typedef logic [TASK_W-1:0] task_idx_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [LVL_W-1:0]  lvl_idx_t;

    localparam link_t NIL_LINK = LINK_W'(TASKS);

    // Task status codes
    localparam logic [1:0] ST_BLOCKED = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_MOVE   = 3'd1,
        FN_REMOVE = 3'd2,
        FN_SCHED  = 3'd3,
        FN_SET    = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MVCHK,
        S_WP,
        S_WN,
        S_WSELF,
        S_WTL,
        S_SCLV,
        S_SCTK,
        S_DONE
    } state_t;

    // One task descriptor word
    typedef struct packed {
        logic       linked;
        logic [1:0] status;
        lvl_idx_t   lvl;
        link_t      prev;
        link_t      next;
    } task_ent_t;

    // One priority level word
    typedef struct packed {
        link_t head;
        link_t tail;
    } level_ent_t;

    localparam int TENT_W = $bits(task_ent_t);
    localparam int LENT_W = $bits(level_ent_t);

    localparam task_ent_t TASK_RST  = '{linked: 1'b0, status: ST_BLOCKED, default: '0};
    localparam task_ent_t MASK_ALL  = '1;
    localparam task_ent_t MASK_ST   = '{linked: 1'b1, status: 2'b11, default: '0};
    localparam task_ent_t MASK_NEXT = '{next: '1, default: '0};
    localparam task_ent_t MASK_PREV = '{prev: '1, default: '0};

    localparam level_ent_t LEVEL_RST = '{head: NIL_LINK, tail: NIL_LINK};

    typedef struct packed {
        logic      we;
        task_idx_t addr;
        task_ent_t data;
        task_ent_t mask;
    } task_wr_t;

    typedef struct packed {
        logic      re;
        task_idx_t addr;
    } task_rd_t;

    typedef struct packed {
        logic       we;
        lvl_idx_t   addr;
        level_ent_t data;
        level_ent_t mask;
    } lvl_wr_t;

    typedef struct packed {
        logic     re;
        lvl_idx_t addr;
    } lvl_rd_t;

    function automatic logic is_nil(link_t l);
        return l >= NIL_LINK;
    endfunction

endpackage

// File: rtl/core/prq_ram.sv
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [WIDTH-1:0]         wmask,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Bit-masked write, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/prq_task_mem.sv
module prq_task_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  prq_pkg::task_wr_t  wr_req,
    input  prq_pkg::task_rd_t  rd_req,
    output prq_pkg::task_ent_t rd_ent
);
    import prq_pkg::*;

    logic [TASKS-1:0]  vld_reg;
    logic              rd_vld_reg;
    logic [TENT_W-1:0] ram_rdata;

    prq_ram #(
        .WIDTH(TENT_W),
        .DEPTH(TASKS)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_req.we),
        .waddr(wr_req.addr),
        .wdata(wr_req.data),
        .wmask(wr_req.mask),
        .re   (rd_req.re),
        .raddr(rd_req.addr),
        .rdata(ram_rdata)
    );

    // An entry becomes valid once its status is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_req.we && (wr_req.mask.status != 2'b00)) begin
                vld_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.re) begin
                rd_vld_reg <= vld_reg[rd_req.addr];
            end
        end
    end

    assign rd_ent = rd_vld_reg ? task_ent_t'(ram_rdata) : TASK_RST;

endmodule

// File: rtl/core/prq_level_mem.sv
module prq_level_mem (
    input  logic                aclk,
    input  logic                aresetn,
    input  prq_pkg::lvl_wr_t    wr_req,
    input  prq_pkg::lvl_rd_t    rd_req,
    output prq_pkg::level_ent_t rd_ent
);
    import prq_pkg::*;

    logic [LEVELS-1:0] vld_reg;
    logic              rd_vld_reg;
    logic [LENT_W-1:0] ram_rdata;

    prq_ram #(
        .WIDTH(LENT_W),
        .DEPTH(LEVELS)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_req.we),
        .waddr(wr_req.addr),
        .wdata(wr_req.data),
        .wmask(wr_req.mask),
        .re   (rd_req.re),
        .raddr(rd_req.addr),
        .rdata(ram_rdata)
    );

    // A level that was never written reads as an empty list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_req.we) begin
                vld_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.re) begin
                rd_vld_reg <= vld_reg[rd_req.addr];
            end
        end
    end

    assign rd_ent = rd_vld_reg ? level_ent_t'(ram_rdata) : LEVEL_RST;

endmodule

// File: rtl/core/priority_ready_queue_scheduler_core.sv
// Multilevel priority ready queue with round-robin order inside each level.
// Every level holds a doubly linked FIFO of task numbers; level 0 is the most
// urgent. One beat on the input stream carries one operation (insert, move to
// end, remove, schedule, set state) and produces exactly one result beat; only
// schedule returns found = 1 with the chosen task, all others return zeros.
// Task descriptors (links, level, status) live in one single-port-read RAM and
// the per-level head/tail pointers in a second one; both have registered reads
// and per-entry valid bits, so no clearing pass is needed after reset and the
// block is ready to accept a beat as soon as aresetn rises.
// An operation that does nothing skips the write states; insert, remove, set
// state and a move step through them, and a move of a linked task first needs
// an extra level RAM read to find its tail. Updates step through a fixed
// sequence of masked writes, one per cycle, on the task RAM write port.
// Schedule scans the levels from level 0 upward and inspects tasks one by one,
// since every list hop is a dependent RAM read. One operation
// is in flight at a time; the next input beat is taken as soon as the previous
// result sits in the output register, even if the sink has not taken it yet.
module priority_ready_queue_scheduler_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input operation stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [6:0] task_req, [11:7] level, [12] make_ready, [15:13] zero
    input  logic [prq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] func
    input  logic [prq_pkg::FUNC_W-1:0]      s_axis_tuser,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] chosen_task, [7] zero
    output logic [prq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] found
    output logic                            m_axis_tuser
);
    import prq_pkg::*;

    // Input field split
    logic [TASK_REQ_W-1:0]  in_task;
    logic [LEVEL_REQ_W-1:0] in_level;
    logic                   in_mr;
    func_t                  in_func;
    logic                   s_accept;

    assign in_task  = s_axis_tdata[6:0];
    assign in_level = s_axis_tdata[11:7];
    assign in_mr    = s_axis_tdata[12];
    assign in_func  = func_t'(s_axis_tuser);

    // Memory ports
    task_wr_t   twr;
    task_rd_t   trd;
    task_ent_t  te;
    lvl_wr_t    lwr;
    lvl_rd_t    lrd;
    level_ent_t le;

    prq_task_mem u_task_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_req (twr),
        .rd_req (trd),
        .rd_ent (te)
    );

    prq_level_mem u_level_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_req (lwr),
        .rd_req (lrd),
        .rd_ent (le)
    );

    // Sequencer state
    state_t     state_reg,     state_next;
    func_t      func_reg,      func_next;
    task_idx_t  task_reg,      task_next;
    lvl_idx_t   lv_reg,        lv_next;
    logic       mr_reg,        mr_next;
    logic       trange_reg,    trange_next;
    logic       lrange_reg,    lrange_next;
    link_t      p_reg,         p_next;
    link_t      n_reg,         n_next;
    link_t      tl_reg,        tl_next;
    task_ent_t  self_reg,      self_next;
    task_ent_t  self_mask_reg, self_mask_next;
    logic       self_en_reg,   self_en_next;
    logic       wp_en_reg,     wp_en_next;
    logic       wn_en_reg,     wn_en_next;
    logic       wtl_en_reg,    wtl_en_next;
    logic       lw_en_reg,     lw_en_next;
    level_ent_t lw_data_reg,   lw_data_next;
    level_ent_t lw_mask_reg,   lw_mask_next;
    logic       found_reg,     found_next;
    task_idx_t  chosen_reg,    chosen_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [CHOSEN_W-1:0] m_task_reg,  m_task_next;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_task_reg);
    assign m_axis_tuser  = m_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        task_reg      <= task_next;
        lv_reg        <= lv_next;
        mr_reg        <= mr_next;
        trange_reg    <= trange_next;
        lrange_reg    <= lrange_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        tl_reg        <= tl_next;
        self_reg      <= self_next;
        self_mask_reg <= self_mask_next;
        self_en_reg   <= self_en_next;
        wp_en_reg     <= wp_en_next;
        wn_en_reg     <= wn_en_next;
        wtl_en_reg    <= wtl_en_next;
        lw_en_reg     <= lw_en_next;
        lw_data_reg   <= lw_data_next;
        lw_mask_reg   <= lw_mask_next;
        found_reg     <= found_next;
        chosen_reg    <= chosen_next;
        m_found_reg   <= m_found_next;
        m_task_reg    <= m_task_next;
    end

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        task_next      = task_reg;
        lv_next        = lv_reg;
        mr_next        = mr_reg;
        trange_next    = trange_reg;
        lrange_next    = lrange_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        tl_next        = tl_reg;
        self_next      = self_reg;
        self_mask_next = self_mask_reg;
        self_en_next   = self_en_reg;
        wp_en_next     = wp_en_reg;
        wn_en_next     = wn_en_reg;
        wtl_en_next    = wtl_en_reg;
        lw_en_next     = lw_en_reg;
        lw_data_next   = lw_data_reg;
        lw_mask_next   = lw_mask_reg;
        found_next     = found_reg;
        chosen_next    = chosen_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_task_next    = m_task_reg;
        trd            = '0;
        lrd            = '0;
        twr            = '0;
        lwr            = '0;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    // Latch the operation and fetch the task and level words
                    func_next    = in_func;
                    task_next    = TASK_W'(in_task);
                    mr_next      = in_mr;
                    trange_next  = 32'(in_task) < TASKS;
                    lrange_next  = 32'(in_level) < LEVELS;
                    lv_next      = (in_func == FN_SCHED) ? '0 : LVL_W'(in_level);
                    self_en_next = 1'b0;
                    wp_en_next   = 1'b0;
                    wn_en_next   = 1'b0;
                    wtl_en_next  = 1'b0;
                    lw_en_next   = 1'b0;
                    found_next   = 1'b0;
                    chosen_next  = '0;
                    trd.re       = 1'b1;
                    trd.addr     = TASK_W'(in_task);
                    lrd.re       = 1'b1;
                    lrd.addr     = (in_func == FN_SCHED) ? '0 : LVL_W'(in_level);
                    state_next   = (in_func == FN_SCHED) ? S_SCLV : S_RD;
                end
            end

            S_RD: begin
                state_next = S_DONE;
                if (trange_reg) begin
                    unique case (func_reg)
                        FN_INSERT: begin
                            if (lrange_reg && !te.linked) begin
                                // Append at the tail of the requested level
                                self_next      = '{linked: 1'b1, status: te.status,
                                                   lvl: lv_reg, prev: le.tail,
                                                   next: NIL_LINK};
                                self_mask_next = MASK_ALL;
                                self_en_next   = 1'b1;
                                tl_next        = le.tail;
                                wtl_en_next    = !is_nil(le.tail);
                                lw_en_next     = 1'b1;
                                lw_data_next   = '{head: LINK_W'(task_reg),
                                                   tail: LINK_W'(task_reg)};
                                lw_mask_next   = '{head: is_nil(le.tail) ? '1 : '0,
                                                   tail: '1};
                                state_next     = S_WP;
                            end
                        end
                        FN_MOVE: begin
                            if (te.linked) begin
                                // Need the level's tail before deciding to move
                                p_next     = te.prev;
                                n_next     = te.next;
                                lv_next    = te.lvl;
                                lrd.re     = 1'b1;
                                lrd.addr   = te.lvl;
                                state_next = S_MVCHK;
                            end else begin
                                self_next        = te;
                                self_next.status = ST_READY;
                                self_mask_next   = MASK_ST;
                                self_en_next     = 1'b1;
                                state_next       = S_WP;
                            end
                        end
                        FN_REMOVE: begin
                            if (te.linked) begin
                                // Unlink and repair both neighbors
                                self_next      = '{linked: 1'b0, status: ST_DEAD,
                                                   lvl: te.lvl, prev: NIL_LINK,
                                                   next: NIL_LINK};
                                self_mask_next = MASK_ALL;
                                p_next         = te.prev;
                                n_next         = te.next;
                                lv_next        = te.lvl;
                                wp_en_next     = !is_nil(te.prev);
                                wn_en_next     = !is_nil(te.next);
                                lw_en_next     = is_nil(te.prev) || is_nil(te.next);
                                lw_data_next   = '{head: te.next, tail: te.prev};
                                lw_mask_next   = '{head: is_nil(te.prev) ? '1 : '0,
                                                   tail: is_nil(te.next) ? '1 : '0};
                            end else begin
                                self_next        = te;
                                self_next.status = ST_DEAD;
                                self_mask_next   = MASK_ST;
                            end
                            self_en_next = 1'b1;
                            state_next   = S_WP;
                        end
                        FN_SET: begin
                            self_next        = te;
                            self_next.status = mr_reg ? ST_READY : ST_BLOCKED;
                            self_mask_next   = MASK_ST;
                            self_en_next     = 1'b1;
                            state_next       = S_WP;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MVCHK: begin
                self_en_next = 1'b1;
                state_next   = S_WP;
                if (le.tail == LINK_W'(task_reg)) begin
                    // Already last in its level: only mark ready
                    self_next      = '{linked: 1'b1, status: ST_READY, default: '0};
                    self_mask_next = MASK_ST;
                end else begin
                    // Detach, then append behind the current tail
                    self_next      = '{linked: 1'b1, status: ST_READY, lvl: lv_reg,
                                       prev: le.tail, next: NIL_LINK};
                    self_mask_next = MASK_ALL;
                    tl_next        = le.tail;
                    wp_en_next     = !is_nil(p_reg);
                    wn_en_next     = 1'b1;
                    wtl_en_next    = 1'b1;
                    lw_en_next     = 1'b1;
                    lw_data_next   = '{head: n_reg, tail: LINK_W'(task_reg)};
                    lw_mask_next   = '{head: is_nil(p_reg) ? '1 : '0, tail: '1};
                end
            end

            S_WP: begin
                // next[prev] = next
                twr.we     = wp_en_reg;
                twr.addr   = TASK_W'(p_reg);
                twr.data   = '{next: n_reg, default: '0};
                twr.mask   = MASK_NEXT;
                state_next = S_WN;
            end

            S_WN: begin
                // prev[next] = prev
                twr.we     = wn_en_reg;
                twr.addr   = TASK_W'(n_reg);
                twr.data   = '{prev: p_reg, default: '0};
                twr.mask   = MASK_PREV;
                state_next = S_WSELF;
            end

            S_WSELF: begin
                twr.we     = self_en_reg;
                twr.addr   = task_reg;
                twr.data   = self_reg;
                twr.mask   = self_mask_reg;
                lwr.we     = lw_en_reg;
                lwr.addr   = lv_reg;
                lwr.data   = lw_data_reg;
                lwr.mask   = lw_mask_reg;
                state_next = S_WTL;
            end

            S_WTL: begin
                // next[old tail] = task
                twr.we     = wtl_en_reg;
                twr.addr   = TASK_W'(tl_reg);
                twr.data   = '{next: LINK_W'(task_reg), default: '0};
                twr.mask   = MASK_NEXT;
                state_next = S_DONE;
            end

            S_SCLV: begin
                if (is_nil(le.head)) begin
                    // Empty level: advance or give up
                    if (lv_reg == LVL_W'(LEVELS - 1)) begin
                        state_next = S_DONE;
                    end else begin
                        lv_next  = lv_reg + 1'b1;
                        lrd.re   = 1'b1;
                        lrd.addr = lv_reg + 1'b1;
                    end
                end else begin
                    task_next  = TASK_W'(le.head);
                    trd.re     = 1'b1;
                    trd.addr   = TASK_W'(le.head);
                    state_next = S_SCTK;
                end
            end

            S_SCTK: begin
                if (te.status == ST_READY) begin
                    found_next  = 1'b1;
                    chosen_next = task_reg;
                    state_next  = S_DONE;
                end else if (is_nil(te.next)) begin
                    if (lv_reg == LVL_W'(LEVELS - 1)) begin
                        state_next = S_DONE;
                    end else begin
                        lv_next    = lv_reg + 1'b1;
                        lrd.re     = 1'b1;
                        lrd.addr   = lv_reg + 1'b1;
                        state_next = S_SCLV;
                    end
                end else begin
                    // Hop to the next task in this level
                    task_next = TASK_W'(te.next);
                    trd.re    = 1'b1;
                    trd.addr  = TASK_W'(te.next);
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_task_next  = CHOSEN_W'(chosen_reg);
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The sequencer never reads an entry in the cycle it writes it
    a_task_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (twr.we && trd.re) |-> (twr.addr != trd.addr))
        else $error("task RAM read and write hit the same entry");

    a_level_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (lwr.we && lrd.re) |-> (lwr.addr != lrd.addr))
        else $error("level RAM read and write hit the same entry");

    a_found_only_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && found_reg) |-> (func_reg == FN_SCHED))
        else $error("found set for an operation other than schedule");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("second beat accepted while an operation is in flight");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && state_next == S_IDLE) |=> m_axis_tvalid)
        else $error("operation finished without a result beat");

endmodule
